@@ rtl/uat_mso_pkg.sv @@
package uat_mso_pkg;

    localparam int unsigned FrameWidth = 16;
    localparam int unsigned PosWidth   = 12;
    localparam int unsigned SlotWidth  = 12;
    localparam int unsigned RandWidth  = 12;
    // 4001*R + N, with 4001*R reduced to 800*(R mod 4) + R, stays below 4*3200
    localparam int unsigned SumWidth   = 14;

    localparam logic [RandWidth-1:0] Modulus    = 12'd3200;
    localparam logic [RandWidth-1:0] Window     = 12'd800;
    localparam logic [SlotWidth-1:0] SlotOffset = 12'd752;

    localparam logic [SumWidth-1:0] Modulus1 = 14'd3200;
    localparam logic [SumWidth-1:0] Modulus2 = 14'd6400;
    localparam logic [SumWidth-1:0] Modulus3 = 14'd9600;

    typedef struct packed {
        logic [FrameWidth-1:0] frame_index;
        logic [PosWidth-1:0]   lat_bits;
        logic [PosWidth-1:0]   lon_bits;
        logic                  restricted_mode;
    } frame_t;

    typedef struct packed {
        logic [SlotWidth-1:0] start_slot;
        logic [RandWidth-1:0] random_value;
    } result_t;

    // Start of the 800-slot window that holds v (v below 3200).
    function automatic logic [RandWidth-1:0] window_floor(input logic [RandWidth-1:0] v);
        logic [RandWidth-1:0] f;
        if (v >= 12'd2400)
        begin
            f = 12'd2400;
        end
        else if (v >= 12'd1600)
        begin
            f = 12'd1600;
        end
        else if (v >= Window)
        begin
            f = Window;
        end
        else
        begin
            f = '0;
        end
        return f;
    endfunction

    // 800 * (r mod 4), which is 4000*r mod 3200 for the recurrence.
    function automatic logic [SumWidth-1:0] quarter_term(input logic [1:0] r_low);
        logic [SumWidth-1:0] q;
        case (r_low)
            2'd0: q = 14'd0;
            2'd1: q = 14'd800;
            2'd2: q = 14'd1600;
            default: q = 14'd2400;
        endcase
        return q;
    endfunction

endpackage

@@ rtl/uat_mso_in_if.sv @@
interface uat_mso_in_if;
    logic                                valid;
    logic                                ready;
    logic [uat_mso_pkg::FrameWidth-1:0]  frame_index;
    logic [uat_mso_pkg::PosWidth-1:0]    lat_bits;
    logic [uat_mso_pkg::PosWidth-1:0]    lon_bits;
    logic                                restricted_mode;

    modport source (output valid, frame_index, lat_bits, lon_bits, restricted_mode,
                    input ready);
    modport sink (input valid, frame_index, lat_bits, lon_bits, restricted_mode,
                  output ready);
endinterface

@@ rtl/uat_mso_out_if.sv @@
interface uat_mso_out_if;
    logic                               valid;
    logic                               ready;
    logic [uat_mso_pkg::SlotWidth-1:0]  start_slot;
    logic [uat_mso_pkg::RandWidth-1:0]  random_value;

    modport source (output valid, start_slot, random_value, input ready);
    modport sink (input valid, start_slot, random_value, output ready);
endinterface

@@ rtl/uat_mso_core.sv @@
module uat_mso_core (
    input  uat_mso_pkg::frame_t                 frame,
    input  logic [uat_mso_pkg::RandWidth-1:0]   prev_random,
    input  logic [uat_mso_pkg::RandWidth-1:0]   restricted_base,
    output uat_mso_pkg::result_t                result
);

    logic [uat_mso_pkg::RandWidth-1:0] seed;
    logic [uat_mso_pkg::PosWidth-1:0]  n_bits;
    logic [uat_mso_pkg::SumWidth-1:0]  sum;
    logic [uat_mso_pkg::SumWidth-1:0]  reduced;
    logic [uat_mso_pkg::RandWidth-1:0] next_random;
    logic [uat_mso_pkg::RandWidth-1:0] r_floor;

    always_comb
    begin
        seed = (frame.lat_bits >= uat_mso_pkg::Modulus)
             ? frame.lat_bits - uat_mso_pkg::Modulus : frame.lat_bits;
        n_bits = frame.frame_index[0] ? frame.lon_bits : frame.lat_bits;

        sum = uat_mso_pkg::quarter_term(prev_random[1:0])
            + uat_mso_pkg::SumWidth'(prev_random)
            + uat_mso_pkg::SumWidth'(n_bits);

        // sum is below 4*3200: pick the multiple to drop in parallel
        if (sum >= uat_mso_pkg::Modulus3)
        begin
            reduced = sum - uat_mso_pkg::Modulus3;
        end
        else if (sum >= uat_mso_pkg::Modulus2)
        begin
            reduced = sum - uat_mso_pkg::Modulus2;
        end
        else if (sum >= uat_mso_pkg::Modulus1)
        begin
            reduced = sum - uat_mso_pkg::Modulus1;
        end
        else
        begin
            reduced = sum;
        end

        next_random = (frame.frame_index == '0) ? seed : reduced[uat_mso_pkg::RandWidth-1:0];
        r_floor     = uat_mso_pkg::window_floor(next_random);

        result.random_value = next_random;
        if (frame.restricted_mode)
        begin
            result.start_slot = uat_mso_pkg::SlotOffset
                              + uat_mso_pkg::window_floor(restricted_base)
                              + (next_random - r_floor);
        end
        else
        begin
            result.start_slot = uat_mso_pkg::SlotOffset + next_random;
        end
    end

endmodule

@@ rtl/uat_message_start_opportunity.sv @@
// UAT message start opportunity selector. Each input word is one frame; each
// output word carries the start slot (752..3951) and the random value R for
// that frame, in frame order. One frame is accepted every cycle while the
// output is not stalled; a frame passes through an input register and a
// result register, which presents its result word on the output. The
// recurrence on R and the saved restricted base are updated as a frame moves
// from the input register to the result register, which keeps the frames in
// strict order. Frame zero reseeds R from the latitude bits.
module uat_message_start_opportunity (
    input  logic           clk,
    input  logic           rst_n,
    uat_mso_in_if.sink     frames,
    uat_mso_out_if.source  slots
);

    logic                              s1_valid_reg;
    uat_mso_pkg::frame_t               s1_frame_reg;
    logic                              out_valid_reg;
    uat_mso_pkg::result_t              out_result_reg;
    logic [uat_mso_pkg::RandWidth-1:0] prev_random_reg;
    logic [uat_mso_pkg::RandWidth-1:0] base_reg;

    uat_mso_pkg::frame_t               in_frame;
    uat_mso_pkg::result_t              result;
    logic                              out_free;
    logic                              advance;
    logic                              accept;

    assign in_frame.frame_index     = frames.frame_index;
    assign in_frame.lat_bits        = frames.lat_bits;
    assign in_frame.lon_bits        = frames.lon_bits;
    assign in_frame.restricted_mode = frames.restricted_mode;

    assign out_free     = !out_valid_reg || slots.ready;
    assign advance      = s1_valid_reg && out_free;
    assign frames.ready = !s1_valid_reg || out_free;
    assign accept       = frames.valid && frames.ready;

    uat_mso_core u_core (
        .frame           (s1_frame_reg),
        .prev_random     (prev_random_reg),
        .restricted_base (base_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_random_reg <= '0;
            base_reg        <= '0;
        end
        else
        begin
            if (frames.ready)
            begin
                s1_valid_reg <= frames.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                prev_random_reg <= result.random_value;
                // only full-mode frames move the window base
                if (!s1_frame_reg.restricted_mode)
                begin
                    base_reg <= result.random_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frame_reg <= in_frame;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign slots.valid        = out_valid_reg;
    assign slots.start_slot   = out_result_reg.start_slot;
    assign slots.random_value = out_result_reg.random_value;

    a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_random_reg < uat_mso_pkg::Modulus && base_reg < uat_mso_pkg::Modulus)
        else $error("random state out of range");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> slots.start_slot >= uat_mso_pkg::SlotOffset
                    && slots.start_slot <= 12'd3951)
        else $error("start slot out of range");

    a_state_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> slots.valid && slots.random_value == prev_random_reg)
        else $error("stored random value differs from delivered word");

    a_base_holds_on_restricted: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_frame_reg.restricted_mode |=> $stable(base_reg))
        else $error("restricted frame changed the window base");

endmodule
